// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the migration candidate queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MCQ_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mcq_pkg.sv -----
// ----------------------------------------------------------------------------
// mcq_pkg
// Types, widths and codes shared by the migration candidate queue modules.
// ----------------------------------------------------------------------------
package mcq_pkg;

    // Sizing
    localparam int QUEUE_DEPTH = 64;
    localparam int PAGE_BITS   = 48;
    localparam int NODE_BITS   = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = COUNT_W + 1;
    localparam int OCC_W       = 7;
    localparam int LIMIT_W     = 7;
    localparam int LIMIT_RESET = 64;
    localparam int LIM_CMP_W   = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIGRATION_DISABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT       = 1'b1;

    // Opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Input word
    typedef struct packed {
        logic                 opcode;
        logic [PAGE_BITS-1:0] page_address;
        logic [NODE_BITS-1:0] target_node;
    } mcq_cand_t;

    // Output word
    typedef struct packed {
        logic                 migrate_valid;
        logic [PAGE_BITS-1:0] migrate_page;
        logic [NODE_BITS-1:0] migrate_node;
        logic                 updated_existing;
        logic                 dropped_oldest;
        logic [OCC_W-1:0]     occupancy;
    } mcq_result_t;

    // One queue entry
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [NODE_BITS-1:0] node;
    } mcq_entry_t;

    // Entry store access for one cycle
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        mcq_entry_t       wdata;
    } mcq_store_req_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_FINISH
    } mcq_state_t;

endpackage

// ----- rtl/mcq_store.sv -----
// ----------------------------------------------------------------------------
// mcq_store
// Entry memory with a registered read port and the page comparator that the
// sequencer shares between the duplicate scan and the zero-page check.
// ----------------------------------------------------------------------------
module mcq_store (
    input  logic                          clk,
    input  mcq_pkg::mcq_store_req_t       req,
    input  logic [mcq_pkg::PAGE_BITS-1:0] key,
    output mcq_pkg::mcq_entry_t           rd_data,
    output logic                          match
);
    import mcq_pkg::*;

    mcq_entry_t mem [QUEUE_DEPTH];
    mcq_entry_t rd_data_reg;

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

    // Shared page comparator
    assign match = (rd_data_reg.page == key);

endmodule

// ----- rtl/migration_candidate_queue.sv -----
// ----------------------------------------------------------------------------
// migration_candidate_queue
// Bounded, deduplicating FIFO of page-migration candidates.
// ----------------------------------------------------------------------------
// Usage:
//   cand channel (cand_valid / cand_stall / cand) carries add and tick words.
//   req channel (req_valid / req_stall / req) returns exactly one result word
//   per accepted input word, in order.
//   cfg_we / cfg_index / cfg_data write migration_disable (0) and
//   queue_limit (1); write only while no word is in flight.
// Timing:
//   An add scans the queue oldest first through one memory read port and
//   one page comparator, one entry per cycle. A tick reads the head entry
//   and then checks its page against the zero page.
//   cand_stall stays high until the result has moved to the output register,
//   so one word is in work at a time.
// Reset:
//   Queue empty, head at slot zero, migration enabled, limit 64. Entry
//   memory is not cleared; only written entries are ever used.
// Backpressure:
//   While req_stall holds a waiting result, the next finished result waits
//   in the sequencer and no new word is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module migration_candidate_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    // input words
    input  logic                           cand_valid,
    output logic                           cand_stall,
    input  mcq_pkg::mcq_cand_t             cand,
    // result words
    output logic                           req_valid,
    input  logic                           req_stall,
    output mcq_pkg::mcq_result_t           req,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [mcq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mcq_pkg::*;

    // Ring position of an offset from the head
    function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0]   head,
                                                 input logic [COUNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    mcq_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_slot_reg, cmp_slot_next;
    mcq_cand_t            key_reg, key_next;
    mcq_result_t          res_reg, res_next;
    mcq_result_t          out_reg, out_next;
    logic                 out_vld_reg, out_vld_next;
    logic                 dis_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    mcq_store_req_t       store_req;
    logic [PAGE_BITS-1:0] store_key;
    mcq_entry_t           store_rd;
    logic                 store_match;

    logic                 cand_take;
    logic                 out_free;
    logic [LIM_CMP_W-1:0] lim_ext, lim_eff;
    logic                 overflow;

    assign cand_stall = (state_reg != ST_IDLE);
    assign cand_take  = cand_valid && !cand_stall;
    assign out_free   = !out_vld_reg || !req_stall;
    assign req_valid  = out_vld_reg;
    assign req        = out_reg;

    // Effective limit and overflow test for an append
    assign lim_ext  = LIM_CMP_W'(limit_reg);
    assign lim_eff  = (lim_ext > LIM_CMP_W'(QUEUE_DEPTH)) ? LIM_CMP_W'(QUEUE_DEPTH) : lim_ext;
    assign overflow = (LIM_CMP_W'(count_reg) + LIM_CMP_W'(1)) > lim_eff;

    // Comparator key: candidate page during scan, zero for the head check
    assign store_key = (state_reg == ST_TICK_CHK) ? '0 : key_reg.page_address;

    mcq_store u_store (
        .clk     (clk),
        .req     (store_req),
        .key     (store_key),
        .rd_data (store_rd),
        .match   (store_match)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cand_take)
                begin
                    state_next = (cand.opcode == OP_TICK) ? ST_TICK_RD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_vld_reg && store_match)
                begin
                    state_next = ST_FINISH;
                end
                else if (scan_idx_reg == count_reg && !cmp_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_TICK_RD:  state_next = ST_TICK_CHK;
            ST_TICK_CHK: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_slot_next = cmp_slot_reg;
        key_next      = key_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        store_req     = '0;

        // Output register drains independently
        if (out_vld_reg && !req_stall)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cand_take)
                begin
                    key_next      = cand;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                end
            end
            ST_SCAN:
            begin
                priority if (cmp_vld_reg && store_match)
                begin
                    // hit: rewrite the node of the oldest match
                    store_req.we         = 1'b1;
                    store_req.waddr      = cmp_slot_reg;
                    store_req.wdata.page = key_reg.page_address;
                    store_req.wdata.node = key_reg.target_node;
                    res_next                  = '0;
                    res_next.updated_existing = 1'b1;
                    res_next.occupancy        = OCC_W'(count_reg);
                end
                else if (scan_idx_reg != count_reg)
                begin
                    // issue next read, compare lands in the next cycle
                    store_req.re  = 1'b1;
                    store_req.raddr = slot_at(head_reg, scan_idx_reg);
                    cmp_slot_next = slot_at(head_reg, scan_idx_reg);
                    cmp_vld_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + COUNT_W'(1);
                end
                else if (cmp_vld_reg)
                begin
                    // last compare missed, settle next cycle
                    cmp_vld_next = 1'b0;
                end
                else
                begin
                    // miss: append, drop the oldest on overflow
                    store_req.we         = 1'b1;
                    store_req.waddr      = slot_at(head_reg, count_reg);
                    store_req.wdata.page = key_reg.page_address;
                    store_req.wdata.node = key_reg.target_node;
                    res_next = '0;
                    if (overflow)
                    begin
                        head_next               = slot_at(head_reg, COUNT_W'(1));
                        res_next.dropped_oldest = 1'b1;
                        res_next.occupancy      = OCC_W'(count_reg);
                    end
                    else
                    begin
                        count_next         = count_reg + COUNT_W'(1);
                        res_next.occupancy = OCC_W'(count_reg + COUNT_W'(1));
                    end
                end
            end
            ST_TICK_RD:
            begin
                store_req.re    = 1'b1;
                store_req.raddr = head_reg;
            end
            ST_TICK_CHK:
            begin
                res_next = '0;
                if (!dis_reg && count_reg != '0 && !store_match)
                begin
                    res_next.migrate_valid = 1'b1;
                    res_next.migrate_page  = store_rd.page;
                    res_next.migrate_node  = store_rd.node;
                    head_next              = slot_at(head_reg, COUNT_W'(1));
                    count_next             = count_reg - COUNT_W'(1);
                    res_next.occupancy     = OCC_W'(count_reg - COUNT_W'(1));
                end
                else
                begin
                    res_next.occupancy = OCC_W'(count_reg);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            dis_reg     <= 1'b0;
            limit_reg   <= LIMIT_W'(LIMIT_RESET);
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIGRATION_DISABLE: dis_reg   <= cfg_data[0];
                    CFG_QUEUE_LIMIT:       limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:               dis_reg   <= dis_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        cmp_slot_reg <= cmp_slot_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // Checks
    `MCQ_ASSERT(a_count_bound, clk, rst_n, 1'b1, count_reg <= COUNT_W'(QUEUE_DEPTH), "count over depth")
    `MCQ_ASSERT(a_write_in_scan, clk, rst_n, store_req.we, state_reg == ST_SCAN, "store write outside scan")
    `MCQ_ASSERT(a_flags_exclusive, clk, rst_n, req_valid, !(req.updated_existing && req.dropped_oldest) && !(req.migrate_valid && (req.updated_existing || req.dropped_oldest)), "result flags overlap")
    `MCQ_ASSERT_NEXT(a_take_busy, clk, rst_n, cand_take, state_reg != ST_IDLE, "accepted word left idle")

endmodule

// ----- tb/tb_migration_candidate_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_migration_candidate_queue
// Self-checking bench for the deduplicating migration candidate queue. A
// queue of pending add and tick words feeds a driver; a monitor mirrors the
// queue state at every accepted word and compares each result word, field by
// field, with the oldest predicted one. Settings change only while idle.
// ----------------------------------------------------------------------------
module tb_migration_candidate_queue;
    import mcq_pkg::*;

    localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cand_valid = 1'b0;
    logic                  cand_stall;
    mcq_cand_t             cand = '0;
    logic                  req_valid;
    logic                  req_stall = 1'b0;
    mcq_result_t           req;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Stimulus and scoreboard storage
    mcq_cand_t   pending_words[$];
    mcq_result_t expected_results[$];

    // Mirror of the queue contents and settings
    logic [PAGE_BITS-1:0] mirror_page [QUEUE_DEPTH];
    logic [NODE_BITS-1:0] mirror_node [QUEUE_DEPTH];
    logic [IDX_W-1:0]     mirror_head = '0;
    int                   mirror_count = 0;
    logic                 mirror_disable = 1'b0;
    logic [LIMIT_W-1:0]   mirror_limit = LIMIT_W'(LIMIT_RESET);

    // Handshake bookkeeping
    bit cand_fire = 1'b0;
    bit jitter_on = 1'b1;
    bit long_hold_done = 1'b0;
    int send_gap = 0;
    int hold_left = 0;
    int results_seen = 0;
    int error_count = 0;

    migration_candidate_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .cand       (cand),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 10 ns clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Advance the mirrored queue by one word and return the result it gives
    function automatic mcq_result_t predict_migration(input mcq_cand_t w);
        mcq_result_t      r;
        int               lim;
        int               i;
        logic [IDX_W-1:0] s;
        bit               hit;
        r = '0;
        hit = 1'b0;
        if (w.opcode == OP_ADD)
        begin
            lim = (mirror_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(mirror_limit);
            // oldest match wins
            for (i = 0; i < mirror_count; i++)
            begin
                s = mirror_head + IDX_W'(i);
                if (!hit && mirror_page[s] == w.page_address)
                begin
                    mirror_node[s] = w.target_node;
                    hit = 1'b1;
                end
            end
            if (hit)
            begin
                r.updated_existing = 1'b1;
            end
            else
            begin
                s = mirror_head + IDX_W'(mirror_count);
                mirror_page[s] = w.page_address;
                mirror_node[s] = w.target_node;
                if (mirror_count + 1 > lim)
                begin
                    mirror_head = mirror_head + IDX_W'(1);
                    r.dropped_oldest = 1'b1;
                end
                else
                begin
                    mirror_count++;
                end
            end
        end
        else if (!mirror_disable && mirror_count > 0 && mirror_page[mirror_head] != '0)
        begin
            // a zero page at the head blocks the pop
            r.migrate_valid = 1'b1;
            r.migrate_page  = mirror_page[mirror_head];
            r.migrate_node  = mirror_node[mirror_head];
            mirror_head = mirror_head + IDX_W'(1);
            mirror_count--;
        end
        r.occupancy = OCC_W'(mirror_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Monitor: predict on each accepted input word, check each result word
    always @(posedge clk)
    begin
        mcq_result_t want;
        mcq_result_t pred;
        cand_fire = cand_valid && !cand_stall;
        if (cand_fire)
        begin
            pred = predict_migration(cand);
            expected_results = {expected_results, pred};
        end
        if (req_valid && !req_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result word with none expected, expected none, actual %h",
                         $time, req);
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                check_field("migrate_valid", 64'(want.migrate_valid),
                            64'(req.migrate_valid));
                check_field("migrate_page", 64'(want.migrate_page),
                            64'(req.migrate_page));
                check_field("migrate_node", 64'(want.migrate_node),
                            64'(req.migrate_node));
                check_field("updated_existing", 64'(want.updated_existing),
                            64'(req.updated_existing));
                check_field("dropped_oldest", 64'(want.dropped_oldest),
                            64'(req.dropped_oldest));
                check_field("occupancy", 64'(want.occupancy), 64'(req.occupancy));
            end
        end
    end

    // Driver: next pending word once the current one is taken, random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!cand_valid || cand_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                cand_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                cand <= pending_words[0];
                pending_words.delete(0);
                cand_valid <= 1'b1;
                if (jitter_on && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 8);
            end
            else
            begin
                cand_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off to fill the block
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                req_stall <= 1'b1;
            end
            else if (!long_hold_done && results_seen >= 300)
            begin
                long_hold_done = 1'b1;
                hold_left = 300;
                req_stall <= 1'b1;
            end
            else if (jitter_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 7);
                req_stall <= 1'b1;
            end
            else
            begin
                req_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_MIGRATION_DISABLE)
            mirror_disable = val[0];
        else
            mirror_limit = LIMIT_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_add(input logic [PAGE_BITS-1:0] page,
                            input logic [NODE_BITS-1:0] node);
        mcq_cand_t w;
        w.opcode       = OP_ADD;
        w.page_address = page;
        w.target_node  = node;
        pending_words = {pending_words, w};
    endtask

    task automatic push_tick();
        mcq_cand_t w;
        w.opcode       = OP_TICK;
        w.page_address = {16'($urandom), $urandom};
        w.target_node  = NODE_BITS'($urandom);
        pending_words = {pending_words, w};
    endtask

    // Random words: adds draw from a small page pool for hits, from the
    // full range for fills, and now and then use the blocking zero page
    task automatic push_random(input int n, input int add_pct);
        int                   k;
        int                   r;
        logic [PAGE_BITS-1:0] page;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < add_pct)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    page = '0;
                else if (r < 50)
                    page = PAGE_BITS'($urandom_range(1, 80));
                else
                    page = {16'($urandom), $urandom};
                push_add(page, NODE_BITS'($urandom));
            end
            else
            begin
                push_tick();
            end
        end
    endtask

    // Wait until every word is sent and every result is back
    task automatic drain();
        while (pending_words.size() != 0 || cand_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: empty tick, hit, zero page blocking the head
        push_tick();
        push_add(PAGE_MAX, 8'hFF);
        push_add(48'd1, 8'h00);
        push_add(PAGE_MAX, 8'h07);
        push_add(48'd0, 8'h5A);
        push_add(48'd2, 8'h80);
        push_tick();
        push_tick();
        push_tick();
        push_add(48'd0, 8'h11);
        drain();

        // Limit lowered to one, below occupancy
        write_reg(CFG_QUEUE_LIMIT, 7'd1);
        push_add(48'd3, 8'h22);
        push_tick();
        push_tick();
        push_add(48'd4, 8'h01);
        push_add(48'd5, 8'h02);
        drain();

        // Ticks while disabled
        write_reg(CFG_MIGRATION_DISABLE, 7'd1);
        push_tick();
        push_add(48'd5, 8'h03);
        drain();

        // Limit zero: an add on an empty queue drops itself
        write_reg(CFG_MIGRATION_DISABLE, 7'd0);
        write_reg(CFG_QUEUE_LIMIT, 7'd0);
        push_tick();
        push_add(48'd6, 8'h04);
        push_tick();
        drain();

        // Limit above depth: fill up and overwrite the oldest slot
        write_reg(CFG_QUEUE_LIMIT, 7'd127);
        push_random(300, 80);
        drain();

        write_reg(CFG_QUEUE_LIMIT, 7'd64);
        push_random(250, 50);
        drain();

        write_reg(CFG_QUEUE_LIMIT, 7'd3);
        push_random(200, 55);
        drain();

        write_reg(CFG_MIGRATION_DISABLE, 7'd1);
        write_reg(CFG_QUEUE_LIMIT, 7'd20);
        push_random(150, 60);
        drain();

        write_reg(CFG_MIGRATION_DISABLE, 7'd0);
        write_reg(CFG_QUEUE_LIMIT, 7'd0);
        push_random(100, 60);
        drain();

        write_reg(CFG_QUEUE_LIMIT, 7'd64);
        push_random(150, 85);
        drain();
        write_reg(CFG_QUEUE_LIMIT, 7'd40);
        push_random(100, 45);
        drain();

        // Final stretch at full rate on both sides
        jitter_on = 1'b0;
        write_reg(CFG_QUEUE_LIMIT, 7'd64);
        push_random(180, 55);
        drain();
        repeat (80) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
